// ===== rtl/ucm_pkg.sv =====
// Package for the UTF-8 decoder with code-point set match.
// Holds the item types, the token passed along the comparator chain and the
// byte classification constants. No dependencies.
package ucm_pkg;

    localparam logic [7:0] MaskTop1   = 8'h80;
    localparam logic [7:0] MaskTop2   = 8'hC0;
    localparam logic [7:0] MaskTop3   = 8'hE0;
    localparam logic [7:0] MaskTop4   = 8'hF0;
    localparam logic [7:0] MaskTop5   = 8'hF8;
    localparam logic [7:0] MaskTop6   = 8'hFC;
    localparam logic [7:0] MaskTop7   = 8'hFE;
    localparam logic [7:0] LeadTwo    = 8'hC0;
    localparam logic [7:0] LeadThree  = 8'hE0;
    localparam logic [7:0] LeadFour   = 8'hF0;
    localparam logic [7:0] LeadFive   = 8'hF8;
    localparam logic [7:0] LeadSix    = 8'hFC;
    localparam logic [7:0] ContTag    = 8'h80;
    localparam logic [7:0] NewlineByte = 8'h0A;
    localparam logic [31:0] LineMax   = 32'hFFFF_FFFF;

    localparam logic ReqText = 1'b0;
    localparam logic ReqLoad = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  text_byte;
        logic [5:0]  entry_index;
        logic [30:0] entry_point;
    } t_in_item;

    typedef struct packed {
        logic [31:0] line_number;
        logic [30:0] code_point;
        logic        is_match;
        logic        bad_byte;
        logic        any_detected;
    } t_out_item;

    // One slot of the comparator chain. A load token carries the slot index and
    // value in idx and point; a result token carries the decoded point.
    typedef struct packed {
        logic        valid;
        logic        is_load;
        logic        bad;
        logic        hit;
        logic [5:0]  idx;
        logic [30:0] point;
        logic [31:0] line;
    } t_token;

endpackage

// ===== rtl/ucm_decoder.sv =====
// UTF-8 front end: keeps the decode state and line counter and turns each load,
// finished character or bad byte into a comparator chain token. Depends on ucm_pkg.
module ucm_decoder (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  ucm_pkg::t_in_item i_item,
    output ucm_pkg::t_token   o_tok
);

    logic [30:0] r_acc, n_acc;
    logic [2:0]  r_rem, n_rem;
    logic [31:0] r_line, n_line;
    logic        r_halted, n_halted;

    logic [7:0] w_b;
    logic       w_done;
    logic       w_bad;

    assign w_b = i_item.text_byte;

    always_comb begin
        n_acc    = r_acc;
        n_rem    = r_rem;
        n_line   = r_line;
        n_halted = r_halted;
        w_done   = 1'b0;
        w_bad    = 1'b0;
        priority if ((w_b & ucm_pkg::MaskTop1) == 8'h00) begin
            n_acc  = {23'd0, w_b};
            w_done = (r_rem == 3'd0);
        end else if ((w_b & ucm_pkg::MaskTop3) == ucm_pkg::LeadTwo) begin
            n_acc = {26'd0, w_b[4:0]};
            n_rem = 3'd1;
        end else if ((w_b & ucm_pkg::MaskTop4) == ucm_pkg::LeadThree) begin
            n_acc = {27'd0, w_b[3:0]};
            n_rem = 3'd2;
        end else if ((w_b & ucm_pkg::MaskTop5) == ucm_pkg::LeadFour) begin
            n_acc = {28'd0, w_b[2:0]};
            n_rem = 3'd3;
        end else if ((w_b & ucm_pkg::MaskTop6) == ucm_pkg::LeadFive) begin
            n_acc = {29'd0, w_b[1:0]};
            n_rem = 3'd4;
        end else if ((w_b & ucm_pkg::MaskTop7) == ucm_pkg::LeadSix) begin
            n_acc = {30'd0, w_b[0]};
            n_rem = 3'd5;
        end else if ((w_b & ucm_pkg::MaskTop2) == ucm_pkg::ContTag) begin
            n_acc  = {r_acc[24:0], w_b[5:0]};
            n_rem  = (r_rem != 3'd0) ? r_rem - 3'd1 : 3'd0;
            w_done = (n_rem == 3'd0);
        end else begin
            w_bad    = 1'b1;
            n_halted = 1'b1;
        end
        if (!w_bad && w_b == ucm_pkg::NewlineByte && r_line != ucm_pkg::LineMax) begin
            n_line = r_line + 32'd1;
        end
    end

    logic w_text;
    assign w_text = i_take && (i_item.req_type == ucm_pkg::ReqText) && !r_halted;

    always_comb begin
        o_tok         = '0;
        o_tok.idx     = i_item.entry_index;
        o_tok.line    = r_line;
        if (i_item.req_type == ucm_pkg::ReqLoad) begin
            o_tok.valid   = i_take;
            o_tok.is_load = 1'b1;
            o_tok.point   = i_item.entry_point;
        end else begin
            o_tok.valid = w_text && (w_done || w_bad);
            o_tok.bad   = w_bad;
            o_tok.point = w_bad ? 31'd0 : n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_rem    <= '0;
            r_line   <= 32'd1;
            r_halted <= 1'b0;
        end else if (w_text) begin
            r_acc    <= n_acc;
            r_rem    <= n_rem;
            r_line   <= n_line;
            r_halted <= n_halted;
        end
    end

endmodule

// ===== rtl/ucm_cell.sv =====
// One comparator cell: holds one set entry, takes loads addressed to it and
// marks a passing code point that equals its entry. Depends on ucm_pkg.
module ucm_cell #(
    parameter int CellIdx = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic [6:0]      i_set_size,
    input  ucm_pkg::t_token i_tok,
    output ucm_pkg::t_token o_tok
);

    logic [30:0]     r_entry;
    ucm_pkg::t_token r_tok, n_tok;
    logic            w_active;
    logic            w_write;

    assign w_active = CellIdx < int'(i_set_size);
    assign w_write  = i_en && i_tok.valid && i_tok.is_load && int'(i_tok.idx) == CellIdx;

    always_comb begin
        n_tok = i_tok;
        if (i_tok.valid && !i_tok.is_load && !i_tok.bad && w_active
                && r_entry == i_tok.point) begin
            n_tok.hit = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_entry <= i_tok.point;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else if (i_en) begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== rtl/utf8_decode_codepoint_match.sv =====
// UTF-8 decoder with code-point set match. One item, text byte or set load, is
// taken per cycle while o_in_stall is low; each result passes through the comparator
// chain and then the output register. While i_out_stall holds a result at the
// output, the whole chain halts and the input is stalled. Loads travel the
// same chain, so they take effect in order with the surrounding text.
module utf8_decode_codepoint_match #(
    parameter int SET_DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [6:0]         i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ucm_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ucm_pkg::t_out_item o_out_item
);

    logic [6:0]         r_set_size;
    logic               r_out_valid;
    ucm_pkg::t_out_item r_out;
    logic               r_det;
    logic               w_en;
    logic               w_take;
    ucm_pkg::t_token    w_tok [SET_DEPTH + 1];
    ucm_pkg::t_token    w_tail;

    // The whole chain moves together whenever the output register can take data.
    assign w_en       = !r_out_valid || !i_out_stall;
    assign o_in_stall = !w_en;
    assign w_take     = i_in_valid && w_en;

    ucm_decoder u_dec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_item  (i_in_item),
        .o_tok   (w_tok[0])
    );

    for (genvar k = 0; k < SET_DEPTH; k++) begin : g_cell
        ucm_cell #(.CellIdx(k)) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_en       (w_en),
            .i_set_size (r_set_size),
            .i_tok      (w_tok[k]),
            .o_tok      (w_tok[k+1])
        );
    end

    assign w_tail = w_tok[SET_DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_size <= '0;
        end else if (i_cfg_we) begin
            r_set_size <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_det       <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_tail.valid && !w_tail.is_load;
            if (w_tail.valid && !w_tail.is_load && w_tail.hit) begin
                r_det <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.line_number  <= w_tail.line;
            r_out.code_point   <= w_tail.point;
            r_out.is_match     <= w_tail.hit;
            r_out.bad_byte     <= w_tail.bad;
            r_out.any_detected <= r_det || w_tail.hit;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ===== rtl/ucm_checker.sv =====
// Port-level checks for utf8_decode_codepoint_match, attached by bind.
// Depends on ucm_pkg.
module ucm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input ucm_pkg::t_out_item o_out_item
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown right after reset");

    a_bad_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.bad_byte |->
            o_out_item.code_point == 31'd0 && !o_out_item.is_match)
        else $error("error item carries a code point or a match");

    a_match_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.is_match |-> o_out_item.any_detected)
        else $error("match without the detected flag");

    a_halt_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && o_out_item.bad_byte |=> !o_out_valid)
        else $error("item delivered after an error item");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

endmodule

bind utf8_decode_codepoint_match ucm_checker u_ucm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
